/* sv/tdq_pkg.sv */
// Shared types and constants for the timer deadline queue.
package tdq_pkg;

  // Fixed field widths of the transaction payloads.
  localparam int ID_W       = 16;
  localparam int STATUS_W   = 3;
  localparam int RESULT_CAP = 16;
  localparam int CNT_W      = $clog2(RESULT_CAP + 1);

  // Time-to-next-deadline codes.
  localparam logic [31:0] NT_EMPTY = 32'hFFFF_FFFF;
  localparam logic [31:0] NT_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] NT_DUE   = 32'h0000_0000;

  // Request function codes.
  typedef enum logic [1:0] {
    FN_ADD_ABS   = 2'd0,
    FN_ADD_DELAY = 2'd1,
    FN_CANCEL    = 2'd2,
    FN_EXPIRE    = 2'd3
  } func_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_CANCELLED = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EXPIRED   = 3'd4,
    ST_NONE_DUE  = 3'd5
  } status_t;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CO_HOLD   = 3'd0,
    CO_INSERT = 3'd1,
    CO_MATCH  = 3'd2,
    CO_REMOVE = 3'd3,
    CO_POP    = 3'd4
  } cell_op_t;

  // Control group sent from the sequencer to the cells.
  typedef struct packed {
    cell_op_t        op;
    logic [ID_W-1:0] new_id;
    logic [ID_W-1:0] match_id;
  } cell_ctl_t;

endpackage

/* sv/tdq_cell.sv */
// One slot of the sorted deadline chain, exchanging entries with its neighbors.
module tdq_cell import tdq_pkg::*; #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cell_ctl_t             ctl,
  input  logic [TIME_WIDTH-1:0] new_deadline,
  input  logic                  left_valid,
  input  logic                  left_gt,
  input  logic [TIME_WIDTH-1:0] left_deadline,
  input  logic [ID_W-1:0]       left_id,
  input  logic                  right_valid,
  input  logic [TIME_WIDTH-1:0] right_deadline,
  input  logic [ID_W-1:0]       right_id,
  input  logic                  hit_in,
  output logic                  cur_valid,
  output logic [TIME_WIDTH-1:0] cur_deadline,
  output logic [ID_W-1:0]       cur_id,
  output logic                  gt,
  output logic                  hit_out
);

  logic                  match;
  logic                  match_next;
  logic                  valid_next;
  logic [TIME_WIDTH-1:0] deadline_next;
  logic [ID_W-1:0]       id_next;

  // Neighbor-facing flags: later than the new deadline, and a match here or to the left.
  assign gt      = cur_valid && (cur_deadline > new_deadline);
  assign hit_out = hit_in | match;

  // Next contents of the slot for each chain operation.
  always_comb begin
    valid_next    = cur_valid;
    deadline_next = cur_deadline;
    id_next       = cur_id;
    match_next    = match;
    case (ctl.op)
      CO_INSERT: begin
        if (left_gt) begin
          valid_next    = left_valid;
          deadline_next = left_deadline;
          id_next       = left_id;
        end else if ((gt || !cur_valid) && left_valid) begin
          valid_next    = 1'b1;
          deadline_next = new_deadline;
          id_next       = ctl.new_id;
        end
      end
      CO_MATCH: begin
        match_next = cur_valid && (cur_id == ctl.match_id);
      end
      CO_REMOVE: begin
        if (hit_out) begin
          valid_next    = right_valid;
          deadline_next = right_deadline;
          id_next       = right_id;
        end
        match_next = 1'b0;
      end
      CO_POP: begin
        valid_next    = right_valid;
        deadline_next = right_deadline;
        id_next       = right_id;
      end
      default: begin
      end
    endcase
  end

  // Control state of the slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      match     <= 1'b0;
    end else begin
      cur_valid <= valid_next;
      match     <= match_next;
    end
  end

  // Payload of the slot.
  always_ff @(posedge clk) begin
    cur_deadline <= deadline_next;
    cur_id       <= id_next;
  end

endmodule

/* sv/timer_deadline_queue_top.sv */
// Top level of the timer deadline queue: request sequencer over a chain of slots.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_stall  | func, now_time, time_arg, target_id
//   out     | out_valid / out_stall| status, entry_id, next_timeout, last
//
// Add and cancel present their result after acceptance through the prepare, chain
// update and report steps. Expire presents its first result after the prepare
// step and then, while the output is not stalled, one per cycle, since the chain
// pops one entry per cycle, up to sixteen results per transaction.
// One request is in flight at a time; in_stall is high while it is worked on.
// A stalled output holds its result and the sequencer waits; the next request
// is still taken while the final result waits. Synchronous reset empties the
// chain at once and clears the id counter; no clearing pass is needed.
module timer_deadline_queue_top import tdq_pkg::*; #(
  parameter int NUM_TIMERS = 16,
  parameter int TIME_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           func,
  input  logic [31:0]          now_time,
  input  logic [31:0]          time_arg,
  input  logic [ID_W-1:0]      target_id,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  status,
  output logic [ID_W-1:0]      entry_id,
  output logic signed [31:0]   next_timeout,
  output logic                 last
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CALC   = 5'b00010,
    S_APPLY  = 5'b00100,
    S_REPORT = 5'b01000,
    S_EXPIRE = 5'b10000
  } state_t;

  state_t                state;
  state_t                state_next;

  // Captured request.
  func_t                 func_q;
  logic [TIME_WIDTH-1:0] now_q;
  logic [TIME_WIDTH-1:0] arg_q;
  logic [ID_W-1:0]       tid_q;
  logic [TIME_WIDTH-1:0] new_dl;
  logic [ID_W-1:0]       id_counter;
  logic [CNT_W-1:0]      exp_cnt;
  status_t               res_status;
  logic [ID_W-1:0]       res_id;

  // Chain wiring.
  cell_ctl_t             ctl;
  logic [NUM_TIMERS-1:0] valid_vec;
  logic [NUM_TIMERS-1:0] gt_vec;
  logic [NUM_TIMERS-1:0] hit_vec;
  logic [TIME_WIDTH-1:0] dl_arr [NUM_TIMERS];
  logic [ID_W-1:0]       id_arr [NUM_TIMERS];
  logic                  second_valid;
  logic [TIME_WIDTH-1:0] second_dl;

  logic [TIME_WIDTH:0]   delay_sum;
  logic                  out_free;
  logic                  full;
  logic                  head_due;
  logic                  second_due;
  logic [NUM_TIMERS-1:0] ordered;

  // Milliseconds from t to deadline d, with the empty, overdue and clipped codes.
  function automatic logic [31:0] time_to(input logic v,
                                          input logic [TIME_WIDTH-1:0] d,
                                          input logic [TIME_WIDTH-1:0] t);
    logic [TIME_WIDTH-1:0] diff;
    logic [63:0]           wide;
    diff = d - t;
    wide = 64'(diff);
    if (!v) begin
      return NT_EMPTY;
    end else if (t >= d) begin
      return NT_DUE;
    end else if (wide > 64'(NT_MAX)) begin
      return NT_MAX;
    end else begin
      return 32'(wide);
    end
  endfunction

  // The chain of slots, slot 0 holding the earliest deadline.
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    logic                  l_valid;
    logic                  l_gt;
    logic [TIME_WIDTH-1:0] l_dl;
    logic [ID_W-1:0]       l_id;
    logic                  r_valid;
    logic [TIME_WIDTH-1:0] r_dl;
    logic [ID_W-1:0]       r_id;
    logic                  h_in;

    if (i == 0) begin : g_head
      assign l_valid = 1'b1;
      assign l_gt    = 1'b0;
      assign l_dl    = '0;
      assign l_id    = '0;
      assign h_in    = 1'b0;
    end else begin : g_body
      assign l_valid = valid_vec[i-1];
      assign l_gt    = gt_vec[i-1];
      assign l_dl    = dl_arr[i-1];
      assign l_id    = id_arr[i-1];
      assign h_in    = hit_vec[i-1];
    end

    if (i == NUM_TIMERS - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_dl    = '0;
      assign r_id    = '0;
    end else begin : g_inner
      assign r_valid = valid_vec[i+1];
      assign r_dl    = dl_arr[i+1];
      assign r_id    = id_arr[i+1];
    end

    tdq_cell #(
      .TIME_WIDTH (TIME_WIDTH)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .ctl            (ctl),
      .new_deadline   (new_dl),
      .left_valid     (l_valid),
      .left_gt        (l_gt),
      .left_deadline  (l_dl),
      .left_id        (l_id),
      .right_valid    (r_valid),
      .right_deadline (r_dl),
      .right_id       (r_id),
      .hit_in         (h_in),
      .cur_valid      (valid_vec[i]),
      .cur_deadline   (dl_arr[i]),
      .cur_id         (id_arr[i]),
      .gt             (gt_vec[i]),
      .hit_out        (hit_vec[i])
    );

    // Sort order between this slot and the next one.
    if (i == NUM_TIMERS - 1) begin : g_ord_tail
      assign ordered[i] = 1'b1;
    end else begin : g_ord
      assign ordered[i] = !valid_vec[i+1] || (dl_arr[i] <= dl_arr[i+1]);
    end
  end

  // Entry behind the head, which becomes the head after a pop.
  if (NUM_TIMERS > 1) begin : g_second
    assign second_valid = valid_vec[1];
    assign second_dl    = dl_arr[1];
  end else begin : g_no_second
    assign second_valid = 1'b0;
    assign second_dl    = '0;
  end

  assign full       = valid_vec[NUM_TIMERS-1];
  assign head_due   = valid_vec[0] && (dl_arr[0] <= now_q);
  assign second_due = second_valid && (second_dl <= now_q);
  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = (state != S_IDLE);
  assign delay_sum  = {1'b0, now_q} + {1'b0, arg_q};

  // Chain command for the current step.
  always_comb begin
    ctl.op       = CO_HOLD;
    ctl.new_id   = id_counter;
    ctl.match_id = tid_q;
    case (state)
      S_CALC: begin
        if (func_q == FN_CANCEL) begin
          ctl.op = CO_MATCH;
        end
      end
      S_APPLY: begin
        if (func_q == FN_CANCEL) begin
          ctl.op = CO_REMOVE;
        end else if (!full) begin
          ctl.op = CO_INSERT;
        end
      end
      S_EXPIRE: begin
        if (out_free && head_due && (exp_cnt < CNT_W'(RESULT_CAP))) begin
          ctl.op = CO_POP;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer transitions.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        state_next = (func_q == FN_EXPIRE) ? S_EXPIRE : S_APPLY;
      end
      S_APPLY: begin
        state_next = S_REPORT;
      end
      S_REPORT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_EXPIRE: begin
        if (out_free) begin
          if (!head_due || !second_due || (exp_cnt >= CNT_W'(RESULT_CAP - 1))) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      id_counter <= '0;
      exp_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CALC) begin
        exp_cnt <= '0;
      end else if (ctl.op == CO_POP) begin
        exp_cnt <= exp_cnt + 1'b1;
      end
      if (ctl.op == CO_INSERT) begin
        id_counter <= id_counter + 1'b1;
      end
      if ((state == S_REPORT || state == S_EXPIRE) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request capture, prepared deadline and pending report.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      func_q <= func_t'(func);
      now_q  <= TIME_WIDTH'(now_time);
      arg_q  <= TIME_WIDTH'(time_arg);
      tid_q  <= target_id;
    end
    if (state == S_CALC) begin
      if (func_q == FN_ADD_DELAY) begin
        new_dl <= delay_sum[TIME_WIDTH] ? '1 : delay_sum[TIME_WIDTH-1:0];
      end else begin
        new_dl <= arg_q;
      end
    end
    if (state == S_APPLY) begin
      if (func_q == FN_CANCEL) begin
        res_status <= hit_vec[NUM_TIMERS-1] ? ST_CANCELLED : ST_NOT_FOUND;
        res_id     <= tid_q;
      end else if (full) begin
        res_status <= ST_FULL;
        res_id     <= '0;
      end else begin
        res_status <= ST_ADDED;
        res_id     <= id_counter;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (state == S_REPORT) begin
        status       <= res_status;
        entry_id     <= res_id;
        next_timeout <= time_to(valid_vec[0], dl_arr[0], now_q);
        last         <= 1'b1;
      end else if (state == S_EXPIRE) begin
        if (ctl.op == CO_POP) begin
          status       <= ST_EXPIRED;
          entry_id     <= id_arr[0];
          next_timeout <= time_to(second_valid, second_dl, now_q);
          last         <= !second_due || (exp_cnt >= CNT_W'(RESULT_CAP - 1));
        end else begin
          status       <= ST_NONE_DUE;
          entry_id     <= '0;
          next_timeout <= time_to(valid_vec[0], dl_arr[0], now_q);
          last         <= 1'b1;
        end
      end
    end
  end

  // Occupied slots always form a prefix of the chain.
  assert property (@(posedge clk) disable iff (rst)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("occupied slots are not contiguous from the head");

  // Occupied slots stay sorted by deadline.
  assert property (@(posedge clk) disable iff (rst) &ordered)
    else $error("slot deadlines out of order");

  // An add into a full queue leaves the chain untouched and keeps the id counter.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY && func_q != FN_CANCEL && full)
      |=> ($stable(valid_vec) && $stable(id_counter)))
    else $error("add into a full queue changed state");

  // An expire never pops more entries than one transaction may report.
  assert property (@(posedge clk) disable iff (rst)
    state == S_EXPIRE |-> exp_cnt < CNT_W'(RESULT_CAP))
    else $error("expire exceeded the result cap");

  // A pop always removes the head and reports an expired entry next.
  assert property (@(posedge clk) disable iff (rst)
    ctl.op == CO_POP |=> (out_valid && status == ST_EXPIRED))
    else $error("pop without an expired result");

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the timer deadline queue top level.
module testbench;
  import tdq_pkg::*;

  localparam int SLOTS       = 16;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int LONG_HOLD   = 300;

  // One expected result transaction.
  typedef struct {
    status_t     code;
    logic [15:0] ident;
    logic [31:0] wait_ms;
    logic        tail;
  } result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          func = FN_EXPIRE;
  logic [31:0]         now_time = 32'd0;
  logic [31:0]         time_arg = 32'd0;
  logic [15:0]         target_id = 16'd0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [2:0]          status;
  logic [15:0]         entry_id;
  logic signed [31:0]  next_timeout;
  logic                last;

  // Predicted contents of the deadline queue.
  logic [31:0] deadline_tab [SLOTS];
  logic [15:0] id_tab [SLOTS];
  int          fill_count = 0;
  logic [15:0] id_next = 16'd0;

  result_t     pending_results [$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  logic [31:0] clock_ms = 32'd5000;
  bit          quiet = 1'b0;
  bit          long_hold_req = 1'b0;

  timer_deadline_queue_top u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .now_time     (now_time),
    .time_arg     (time_arg),
    .target_id    (target_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .entry_id     (entry_id),
    .next_timeout (next_timeout),
    .last         (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timer_deadline_queue_top regression: fail");
      $finish;
    end
  end

  // Idle length: none when quiet; else mostly none, sometimes short, rarely a long stretch.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Time from now to the head deadline, as reported with each result.
  function automatic logic [31:0] time_to_head(input logic [31:0] now);
    logic [31:0] diff;
    if (fill_count == 0) return NT_EMPTY;
    if (now >= deadline_tab[0]) return NT_DUE;
    diff = deadline_tab[0] - now;
    return (diff > NT_MAX) ? NT_MAX : diff;
  endfunction

  function automatic void push_result(input status_t code, input logic [15:0] ident,
                                      input logic [31:0] now);
    result_t r;
    r.code    = code;
    r.ident   = ident;
    r.wait_ms = time_to_head(now);
    r.tail    = 1'b0;
    pending_results.push_back(r);
  endfunction

  // Close the gap left by a removed slot.
  function automatic void remove_slot(input int idx);
    int k;
    for (k = idx; k + 1 < fill_count; k++) begin
      deadline_tab[k] = deadline_tab[k + 1];
      id_tab[k]       = id_tab[k + 1];
    end
    fill_count--;
  endfunction

  // Apply one accepted request to the predicted queue and queue its results.
  function automatic void queue_apply(input func_t f, input logic [31:0] now,
                                      input logic [31:0] arg, input logic [15:0] tid);
    logic [32:0] sum;
    logic [31:0] due;
    logic [15:0] popped_id;
    result_t     final_r;
    int          pos;
    int          hit;
    int          popped;
    int          k;
    hit = -1;
    popped = 0;
    case (f)
      FN_ADD_ABS, FN_ADD_DELAY: begin
        sum = {1'b0, now} + {1'b0, arg};
        if (f == FN_ADD_ABS) due = arg;
        else due = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        if (fill_count == SLOTS) begin
          push_result(ST_FULL, 16'd0, now);
        end else begin
          // Insert after every entry whose deadline is not later.
          pos = fill_count;
          while (pos > 0 && deadline_tab[pos - 1] > due) begin
            deadline_tab[pos] = deadline_tab[pos - 1];
            id_tab[pos]       = id_tab[pos - 1];
            pos--;
          end
          deadline_tab[pos] = due;
          id_tab[pos]       = id_next;
          fill_count++;
          push_result(ST_ADDED, id_next, now);
          id_next++;
        end
      end
      FN_CANCEL: begin
        for (k = 0; k < fill_count && hit < 0; k++)
          if (id_tab[k] == tid) hit = k;
        if (hit >= 0) begin
          remove_slot(hit);
          push_result(ST_CANCELLED, tid, now);
        end else begin
          push_result(ST_NOT_FOUND, tid, now);
        end
      end
      default: begin
        while (popped < RESULT_CAP && fill_count > 0 && deadline_tab[0] <= now) begin
          popped_id = id_tab[0];
          remove_slot(0);
          push_result(ST_EXPIRED, popped_id, now);
          popped++;
        end
        if (popped == 0) push_result(ST_NONE_DUE, 16'd0, now);
      end
    endcase
    final_r = pending_results.pop_back();
    final_r.tail = 1'b1;
    pending_results.push_back(final_r);
  endfunction

  // Offer one request transaction and wait until the block takes it.
  task automatic send_req(input func_t f, input logic [31:0] now, input logic [31:0] arg,
                          input logic [15:0] tid);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= f;
    now_time  <= now;
    time_arg  <= arg;
    target_id <= tid;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    queue_apply(f, now, arg, tid);
  endtask

  // Stop offering requests and wait for every expected result.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Mostly well-formed traffic around a slowly advancing clock, with some noise.
  task automatic random_request();
    int          r;
    func_t       f;
    logic [31:0] now;
    logic [31:0] arg;
    logic [15:0] tid;
    if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
    clock_ms = clock_ms + $urandom_range(0, 40);
    now = clock_ms;
    tid = $urandom_range(0, 65535);
    arg = $urandom;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      f = FN_ADD_ABS;
      arg = clock_ms + $urandom_range(0, 300);
    end else if (r < 45) begin
      f = FN_ADD_DELAY;
      arg = $urandom_range(0, 300);
    end else if (r < 67) begin
      f = FN_CANCEL;
      if (fill_count > 0 && $urandom_range(0, 3) != 0)
        tid = id_tab[$urandom_range(0, fill_count - 1)];
    end else begin
      f = FN_EXPIRE;
    end
    if ($urandom_range(0, 9) == 0) begin
      now = $urandom;
      arg = $urandom;
    end
    send_req(f, now, arg, tid);
  endtask

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  // Result side: check each accepted transaction and drive random stalls.
  initial begin : result_monitor
    result_t want;
    int      stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result: expected none, actual status %0h id %0h",
                   $time, status, entry_id);
        end else begin
          want = pending_results.pop_front();
          report_field("status", want.code, status);
          report_field("entry_id", want.ident, entry_id);
          report_field("next_timeout", want.wait_ms, next_timeout);
          report_field("last", want.tail, last);
        end
      end
      // The long hold is counted here so the sender keeps running meanwhile.
      if (long_hold_req) begin
        stall_left = LONG_HOLD;
        long_hold_req = 1'b0;
      end else if (stall_left == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Expire and cancel on an empty queue.
  task automatic test_empty_queue();
    send_req(FN_EXPIRE, 32'd0, 32'd0, 16'd0);
    send_req(FN_CANCEL, 32'd0, 32'd0, 16'hFFFF);
    send_req(FN_CANCEL, 32'd0, 32'hFFFF_FFFF, 16'd0);
  endtask

  // Fill every slot with ties, overdue and saturated deadlines, overflow, cancel and refill one, then drain at once.
  task automatic test_fill_and_overflow();
    int          i;
    logic [31:0] arg;
    for (i = 0; i < SLOTS; i++) begin
      case (i % 4)
        0: arg = 32'd0;
        1: arg = 32'hFFFF_FFFF;
        default: arg = 32'd500;
      endcase
      send_req(i[0] ? FN_ADD_DELAY : FN_ADD_ABS,
               (i == 5) ? 32'hFFFF_FF00 : 32'd1000 - i, arg, 16'd0);
    end
    send_req(FN_ADD_DELAY, 32'd2000, 32'd1, 16'd0);
    send_req(FN_CANCEL, 32'd2000, 32'd0, id_tab[SLOTS / 2]);
    send_req(FN_ADD_ABS, 32'd0, 32'hFFFF_FFFF, 16'd0);
    send_req(FN_EXPIRE, 32'hFFFF_FFFF, 32'd0, 16'd0);
  endtask

  // Far deadlines report a clipped timeout; a near one counts down exactly.
  task automatic test_timeout_saturation();
    send_req(FN_ADD_ABS, 32'd0, 32'hFFFF_FFFF, 16'd0);
    send_req(FN_ADD_DELAY, 32'd10, 32'd5, 16'd0);
    send_req(FN_EXPIRE, 32'd15, 32'd0, 16'd0);
  endtask

  task automatic test_random_traffic(input int count, input bit calm);
    quiet = calm;
    repeat (count) random_request();
    quiet = 1'b0;
  endtask

  // Receiver holds off while requests keep coming, then the sender drains.
  task automatic test_receiver_hold();
    long_hold_req = 1'b1;
    repeat (12) random_request();
    wait_idle();
  endtask

  // Test sequence.
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_empty_queue();
    test_fill_and_overflow();
    test_timeout_saturation();
    test_random_traffic(30, 1'b0);
    test_receiver_hold();
    test_random_traffic(15, 1'b1);
    test_random_traffic(15, 1'b0);
    wait_idle();
    repeat (24) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("timer_deadline_queue_top regression: pass");
    end else begin
      $display("timer_deadline_queue_top regression: fail");
    end
    $finish;
  end

endmodule
